### hw/rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII unit.
// Used by the controller, the datapath and the top level; no dependencies.
package b2da_pkg;

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(NUM_W - 1);
  localparam logic [IDX_W-1:0]  TOP_IDX    = IDX_W'(BCD_DIGITS - 1);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic digit_zero;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/b2da_ctrl.sv
// Controller state machine of the binary to decimal ASCII unit.
// Depends on b2da_pkg; drives commands into b2da_dp and reads its status.
module b2da_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  b2da_pkg::sts_t sts_i,
  output b2da_pkg::cmd_t cmd_o
);
  import b2da_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts_i.conv_done) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts_i.digit_zero || sts_i.idx_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.idx_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_CONVERT: cmd_o.shift = 1'b1;
      ST_SKIP:    cmd_o.skip  = sts_i.digit_zero && !sts_i.idx_last;
      ST_EMIT:    cmd_o.emit  = sts_i.out_free;
      default:    cmd_o       = '0;
    endcase
  end

endmodule

### hw/rtl/b2da_dp.sv
// Datapath of the binary to decimal ASCII unit: shift-add-3 converter,
// digit walker and output register. Depends on b2da_pkg.
module b2da_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  b2da_pkg::cmd_t                   cmd_i,
  output b2da_pkg::sts_t                   sts_o,
  input  logic [b2da_pkg::NUM_W-1:0]       number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                             last_digit_o
);
  import b2da_pkg::*;

  logic [NUM_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              valid_q, valid_d;
  logic [3:0]        top_digit;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  assign sts_o.conv_done  = (cnt_q == LAST_SHIFT);
  assign sts_o.digit_zero = (top_digit == 4'd0);
  assign sts_o.idx_last   = (idx_q == '0);
  assign sts_o.out_free   = !valid_q || out_ready_i;

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = valid_q && !out_ready_i;
    if (cmd_i.load) begin
      bin_d = number_i;
      bcd_d = '0;
      cnt_d = '0;
      idx_d = TOP_IDX;
    end
    if (cmd_i.shift) begin
      {bcd_d, bin_d} = {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
      cnt_d          = cnt_q + 1'b1;
    end
    if (cmd_i.skip || cmd_i.emit) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
      idx_d = idx_q - 1'b1;
    end
    if (cmd_i.emit) begin
      char_d  = ASCII_ZERO + CHAR_W'(top_digit);
      last_d  = (idx_q == '0);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

### hw/rtl/binary_to_decimal_ascii_unit.sv
// Unsigned 32-bit binary to decimal ASCII converter, top level.
// A request is taken in the idle state and converted by bit-serial shift-add-3 steps;
// leading zero digits are then skipped, and the digits are walked into the output
// register one digit per cycle while the output is not stalled; a new request is
// taken only once the last digit has been emitted.
// Reset clears the state machine and the output valid flag. Depends on b2da_pkg.
module binary_to_decimal_ascii_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [b2da_pkg::NUM_W-1:0]             s_axis_tdata,  // [31:0] number
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [b2da_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [5:0] digit_char, [7:6] 0
  output logic                                   m_axis_tlast   // last_digit
);
  import b2da_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [CHAR_W-1:0] digit_char;

  b2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  b2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .number_i     (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .digit_char_o (digit_char),
    .last_digit_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, digit_char};

endmodule

### sim/binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for binary_to_decimal_ascii_unit: streams 32-bit numbers in
// bursts, predicts their decimal digit characters and checks every digit and tlast.
// Depends on b2da_pkg and the binary_to_decimal_ascii_unit RTL.
module binary_to_decimal_ascii_unit_tb;

  localparam int unsigned N_RANDOM   = 420;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_WAIT  = 120;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] digit_char;
    logic                        last_digit;
  } digit_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [b2da_pkg::NUM_W-1:0]        s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [b2da_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              m_axis_tlast;

  logic [b2da_pkg::NUM_W-1:0] pending_numbers[$];
  digit_t                     expected_digits[$];

  int unsigned errors = 0;
  int unsigned numbers_sent = 0;
  int unsigned numbers_taken = 0;
  int unsigned digits_seen = 0;
  int unsigned ten_digit_numbers = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_directed = 0;
  int          drained_at = -1;
  bit          req_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_cycle = 0;

  binary_to_decimal_ascii_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_digits(input logic [b2da_pkg::NUM_W-1:0] number);
    logic [3:0]                 rev[10];
    logic [b2da_pkg::NUM_W-1:0] rest;
    int                         count;
    digit_t                     d;
    rest  = number;
    count = 0;
    do begin
      rev[count] = 4'(rest % 10);
      rest       = rest / 10;
      count++;
    end while (rest != 0 && count < 10);
    if (count == 10) ten_digit_numbers++;
    for (int k = count - 1; k >= 0; k--) begin
      d.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[k]);
      d.last_digit = (k == 0);
      expected_digits.push_back(d);
    end
  endtask

  // sample both handshakes, predict, check
  always @(posedge clk_i) begin
    digit_t exp_d;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata);
        numbers_taken++;
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          $error("unexpected digit: tdata %0d tlast %0b", m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          exp_d = expected_digits.pop_front();
          if (m_axis_tdata[b2da_pkg::CHAR_W-1:0] !== exp_d.digit_char) begin
            $error("digit_char: expected %0d, got %0d", exp_d.digit_char,
                   m_axis_tdata[b2da_pkg::CHAR_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[b2da_pkg::OUT_DATA_W-1:b2da_pkg::CHAR_W] !== '0) begin
            $error("tdata pad: expected 0, got %0d",
                   m_axis_tdata[b2da_pkg::OUT_DATA_W-1:b2da_pkg::CHAR_W]);
            errors++;
          end
          if (m_axis_tlast !== exp_d.last_digit) begin
            $error("last_digit: expected %0b, got %0b", exp_d.last_digit, m_axis_tlast);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // sender: bursts with gaps, and a hold until drained at two points
  always @(negedge clk_i) begin
    logic                       nv;
    logic [b2da_pkg::NUM_W-1:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (req_taken) begin
      req_taken = 1'b0;
      nv        = 1'b0;
    end
    if (rst_ni && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if ((numbers_sent == n_directed || numbers_sent == n_directed + 200) &&
                   drained_at != int'(numbers_sent)) begin
        if (expected_digits.size() == 0) drained_at = numbers_sent;
      end else if (pending_numbers.size() > 0) begin
        nd = pending_numbers.pop_front();
        nv = 1'b1;
        numbers_sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // receiver: stall mode drawn at random from four modes
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rx_cycle % 11) < 4);
    endcase
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("binary_to_decimal_ascii_unit: mismatch");
    $finish;
  end

  initial begin
    longint                     lo;
    longint                     hi;
    logic [b2da_pkg::NUM_W-1:0] value;
    int unsigned                digits;
    pending_numbers = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF,
                        32'hFFFF_FFFE, 32'd1_000_000_000, 32'd999_999_999,
                        32'd4_000_000_000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'd0, 32'd7, 32'd12345, 32'd1_000_000, 32'd9999,
                        32'd10000, 32'd65535, 32'd65536};
    n_directed = pending_numbers.size();
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: value = $urandom() >> $urandom_range(0, 31);
        1: begin
          digits = $urandom_range(1, 10);
          lo     = 1;
          repeat (digits - 1) lo = lo * 10;
          hi = lo * 10 - 1;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          value = $urandom_range(hi[31:0], lo[31:0]);
        end
        2: begin
          lo = 1;
          repeat ($urandom_range(0, 9)) lo = lo * 10;
          value = lo[31:0] - $urandom_range(0, 1);
        end
        default: value = $urandom();
      endcase
      pending_numbers.push_back(value);
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_numbers.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Converted %0d numbers (%0d with ten digits) into %0d checked digits,",
             numbers_taken, ten_digit_numbers, digits_seen);
    $display("under sender bursts and gaps and four receiver stall modes.");
    if (errors == 0 && expected_digits.size() == 0) begin
      $display("binary_to_decimal_ascii_unit: match");
    end else begin
      $display("binary_to_decimal_ascii_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_ctrl.sv
hw/rtl/b2da_dp.sv
hw/rtl/binary_to_decimal_ascii_unit.sv
sim/binary_to_decimal_ascii_unit_tb.sv
